// File: rtl/voice_turn_endpoint_barge_fsm_unit_macros.svh
// Assertion macros for the voice turn controller.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef VOICE_TURN_ENDPOINT_BARGE_FSM_UNIT_MACROS_SVH
`define VOICE_TURN_ENDPOINT_BARGE_FSM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VTEB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define VTEB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VTEB_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define VTEB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/vteb_pkg.sv
// Shared types and codes for the voice turn controller.
// No dependencies.
package vteb_pkg;

  localparam int FRAME_MS_DEF = 20;

  localparam int CMD_W   = 3;
  localparam int LEVEL_W = 15;
  localparam int MODE_W  = 2;
  localparam int EVENT_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_FRAME        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TTS_BEGIN    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TTS_DRAINED  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP         = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SERVER_ERROR = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TEXT_REQUEST = 3'd6;
  localparam logic [CMD_W-1:0] CMD_INTERRUPT    = 3'd7;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LISTEN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_THINK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPEAK  = 2'd3;

  localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
  localparam logic [EVENT_W-1:0] EV_SPEECH_START = 3'd1;
  localparam logic [EVENT_W-1:0] EV_SPEECH_END   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT      = 3'd3;
  localparam logic [EVENT_W-1:0] EV_BARGE_IN     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LISTEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BARGE_FRAMES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BARGE_FACTOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BARGE_MIN     = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               is_speech;
    logic [LEVEL_W-1:0] frame_level;
    logic [LEVEL_W-1:0] noise_level;
    logic               continuous_mode;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [EVENT_W-1:0] event_res;
    logic               mode_changed;
  } result_t;

  typedef struct packed {
    logic [15:0]        silence_limit_ms;
    logic [15:0]        max_listen_ms;
    logic [7:0]         speech_start_frames;
    logic [7:0]         barge_frames;
    logic [3:0]         barge_factor;
    logic [LEVEL_W-1:0] barge_min_level;
  } cfg_t;

endpackage

// File: rtl/vteb_ifs.sv
// Valid/ready channel interfaces for frame items and turn results.
// Depends on vteb_pkg.
interface vteb_in_if;
  logic                          valid;
  logic                          ready;
  logic [vteb_pkg::CMD_W-1:0]    cmd;
  logic                          is_speech;
  logic [vteb_pkg::LEVEL_W-1:0]  frame_level;
  logic [vteb_pkg::LEVEL_W-1:0]  noise_level;
  logic                          continuous_mode;

  modport source (output valid, cmd, is_speech, frame_level, noise_level, continuous_mode,
                  input ready);
  modport sink (input valid, cmd, is_speech, frame_level, noise_level, continuous_mode,
                output ready);
endinterface

interface vteb_out_if;
  logic                          valid;
  logic                          ready;
  logic [vteb_pkg::MODE_W-1:0]   mode;
  logic [vteb_pkg::EVENT_W-1:0]  event_res;
  logic                          mode_changed;

  modport source (output valid, mode, event_res, mode_changed, input ready);
  modport sink (input valid, mode, event_res, mode_changed, output ready);
endinterface

// File: rtl/vteb_core.sv
// Turn state registers and per-item next-state logic of the voice turn controller.
// Depends on vteb_pkg and the assertion macro header.
`include "voice_turn_endpoint_barge_fsm_unit_macros.svh"

module vteb_core #(
  parameter int FRAME_MS = vteb_pkg::FRAME_MS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  vteb_pkg::item_t   item,
  input  vteb_pkg::cfg_t    cfg,
  output vteb_pkg::result_t res
);
  import vteb_pkg::*;

  localparam logic [6:0] STEP = 7'(FRAME_MS);

  function automatic logic [15:0] sat_add16(input logic [15:0] a);
    logic [16:0] s;
    s = {1'b0, a} + {10'b0, STEP};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] a);
    return (a == 8'hFF) ? a : a + 8'd1;
  endfunction

  logic [MODE_W-1:0] mode, mode_next;
  logic [7:0]  voice_cnt, voice_cnt_next;
  logic [15:0] silence_time, silence_time_next;
  logic [15:0] listen_time, listen_time_next;
  logic [7:0]  loud_run, loud_run_next;
  logic        speech_begun, speech_begun_next;
  logic        in_session, in_session_next;
  logic        continuous, continuous_next;

  logic [EVENT_W-1:0] ev;
  logic        do_round, do_idle, do_barge;
  logic [15:0] limit;
  logic [18:0] prod;
  logic [18:0] thresh;
  logic        round_reset;

  always_comb begin
    mode_next         = mode;
    voice_cnt_next    = voice_cnt;
    silence_time_next = silence_time;
    listen_time_next  = listen_time;
    loud_run_next     = loud_run;
    speech_begun_next = speech_begun;
    in_session_next   = in_session;
    continuous_next   = continuous;
    ev       = EV_NONE;
    do_round = 1'b0;
    do_idle  = 1'b0;
    do_barge = 1'b0;
    limit  = (cfg.silence_limit_ms == 16'd0) ? 16'd800 : cfg.silence_limit_ms;
    prod   = {4'b0, item.noise_level} * {15'b0, cfg.barge_factor};
    thresh = (prod < {4'b0, cfg.barge_min_level}) ? {4'b0, cfg.barge_min_level} : prod;

    case (item.cmd)
      CMD_FRAME: begin
        if (mode == MODE_LISTEN) begin
          listen_time_next = sat_add16(listen_time);
          if (item.is_speech) begin
            voice_cnt_next    = sat_inc8(voice_cnt);
            silence_time_next = 16'd0;
          end else begin
            voice_cnt_next    = 8'd0;
            silence_time_next = sat_add16(silence_time);
          end
          if (!speech_begun && voice_cnt_next >= cfg.speech_start_frames) begin
            speech_begun_next = 1'b1;
            ev = EV_SPEECH_START;
          end
          if (speech_begun_next && silence_time_next >= limit) begin
            ev = EV_SPEECH_END;
            mode_next = MODE_THINK;
          end else if (!speech_begun_next && listen_time_next >= cfg.max_listen_ms &&
                       !continuous) begin
            ev = EV_TIMEOUT;
            do_idle = 1'b1;
          end
        end else if (mode == MODE_SPEAK) begin
          loud_run_next = ({4'b0, item.frame_level} > thresh) ? sat_inc8(loud_run) : 8'd0;
          if (loud_run_next >= cfg.barge_frames) begin
            ev = EV_BARGE_IN;
            do_barge = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (mode != MODE_IDLE) begin
          if (item.continuous_mode) continuous_next = 1'b1;
        end else begin
          continuous_next = item.continuous_mode;
          in_session_next = 1'b1;
          do_round = 1'b1;
        end
      end
      CMD_TTS_BEGIN: begin
        loud_run_next = 8'd0;
        mode_next = MODE_SPEAK;
      end
      CMD_TTS_DRAINED: begin
        if (mode == MODE_SPEAK) begin
          if (in_session && continuous) do_round = 1'b1;
          else do_idle = 1'b1;
        end
      end
      CMD_STOP: begin
        continuous_next = 1'b0;
        do_idle = 1'b1;
      end
      CMD_SERVER_ERROR: begin
        if (in_session && continuous) do_round = 1'b1;
        else do_idle = 1'b1;
      end
      CMD_TEXT_REQUEST: begin
        if (mode == MODE_IDLE) mode_next = MODE_THINK;
      end
      default: begin
        if (mode == MODE_SPEAK) begin
          ev = EV_BARGE_IN;
          do_barge = 1'b1;
        end
      end
    endcase

    round_reset = do_round || (do_barge && in_session);
    if (do_barge && !in_session) do_idle = 1'b1;

    if (round_reset) begin
      voice_cnt_next    = 8'd0;
      silence_time_next = 16'd0;
      speech_begun_next = 1'b0;
      listen_time_next  = 16'd0;
      loud_run_next     = 8'd0;
      mode_next         = MODE_LISTEN;
    end
    // barge-in resumes listening with the user already talking
    if (do_barge && in_session) begin
      speech_begun_next = 1'b1;
      voice_cnt_next    = cfg.speech_start_frames;
    end
    if (do_idle) begin
      in_session_next = 1'b0;
      mode_next       = MODE_IDLE;
    end

    res.mode         = mode_next;
    res.event_res    = ev;
    res.mode_changed = (mode_next != mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      voice_cnt    <= 8'd0;
      silence_time <= 16'd0;
      listen_time  <= 16'd0;
      loud_run     <= 8'd0;
      speech_begun <= 1'b0;
      in_session   <= 1'b0;
      continuous   <= 1'b0;
    end else if (fire) begin
      mode         <= mode_next;
      voice_cnt    <= voice_cnt_next;
      silence_time <= silence_time_next;
      listen_time  <= listen_time_next;
      loud_run     <= loud_run_next;
      speech_begun <= speech_begun_next;
      in_session   <= in_session_next;
      continuous   <= continuous_next;
    end
  end

  `VTEB_ASSERT_NOW(a_barge_dest, clk, rst, fire && res.event_res == EV_BARGE_IN,
                   res.mode == MODE_LISTEN || res.mode == MODE_IDLE)
  `VTEB_ASSERT_NXT(a_end_thinks, clk, rst, fire && res.event_res == EV_SPEECH_END,
                   mode == MODE_THINK && speech_begun)
  `VTEB_ASSERT_NXT(a_hold, clk, rst, !fire,
                   $stable(mode) && $stable(listen_time) && $stable(in_session))

endmodule

// File: rtl/voice_turn_endpoint_barge_fsm_unit.sv
// Voice turn controller: one input register, next-state logic, one result register.
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless results.ready stalls the result register.
// Reset (synchronous): idle mode, all counters and session flags cleared,
// configuration registers back to their defaults, both pipeline stages empty.
// Depends on vteb_pkg, vteb_ifs, vteb_core and the assertion macro header.
`include "voice_turn_endpoint_barge_fsm_unit_macros.svh"

module voice_turn_endpoint_barge_fsm_unit #(
  parameter int FRAME_MS = vteb_pkg::FRAME_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [vteb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vteb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  vteb_in_if.sink                           items,
  vteb_out_if.source                        results
);
  import vteb_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    adv;
  logic    fire;

  assign adv         = !out_valid || results.ready;
  assign fire        = s1_valid && adv;
  assign items.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.silence_limit_ms    <= 16'd800;
      cfg.max_listen_ms       <= 16'd15000;
      cfg.speech_start_frames <= 8'd3;
      cfg.barge_frames        <= 8'd12;
      cfg.barge_factor        <= 4'd6;
      cfg.barge_min_level     <= 15'd500;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SILENCE_LIMIT: cfg.silence_limit_ms    <= cfg_wdata;
        CFG_MAX_LISTEN:    cfg.max_listen_ms       <= cfg_wdata;
        CFG_SPEECH_START:  cfg.speech_start_frames <= cfg_wdata[7:0];
        CFG_BARGE_FRAMES:  cfg.barge_frames        <= cfg_wdata[7:0];
        CFG_BARGE_FACTOR:  cfg.barge_factor        <= cfg_wdata[3:0];
        CFG_BARGE_MIN:     cfg.barge_min_level     <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_item.cmd             <= items.cmd;
      s1_item.is_speech       <= items.is_speech;
      s1_item.frame_level     <= items.frame_level;
      s1_item.noise_level     <= items.noise_level;
      s1_item.continuous_mode <= items.continuous_mode;
    end
  end

  vteb_core #(
    .FRAME_MS(FRAME_MS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign results.valid        = out_valid;
  assign results.mode         = out_res.mode;
  assign results.event_res    = out_res.event_res;
  assign results.mode_changed = out_res.mode_changed;

  `VTEB_ASSERT_NOW(a_stall_blocks, clk, rst, s1_valid && out_valid && !results.ready, !items.ready)
  `VTEB_ASSERT_NXT(a_accept_fills, clk, rst, items.valid && items.ready, s1_valid)
  `VTEB_ASSERT_NXT(a_fire_shows, clk, rst, fire, out_valid)

endmodule
